@@ design/gsr_pkg.sv @@
// shared types and constants for the gamepad shift reader
// no dependencies; imported by the sequencer, the output buffer and the top level
package gsr_pkg;

    localparam int BUTTON_BITS = 16;
    localparam int BIT_IDX_W   = $clog2(BUTTON_BITS + 1);
    localparam int BUTTONS_W   = 16;
    localparam int PERIOD_W    = 20;
    localparam int TIMER_W     = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PERIOD_W-1:0]    COUNT_MAX   = {PERIOD_W{1'b1}};
    localparam logic [BUTTON_BITS-1:0] WORD_ONES   = {BUTTON_BITS{1'b1}};

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_READ_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LATCH       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HALF  = 2'd2;

    localparam logic [PERIOD_W-1:0] RESET_READ_PERIOD = 20'd16667;
    localparam logic [TIMER_W-1:0]  RESET_LATCH       = 8'd12;
    localparam logic [TIMER_W-1:0]  RESET_CLOCK_HALF  = 8'd5;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LATCH    = 2'd1,
        PH_CLK_LOW  = 2'd2,
        PH_CLK_HIGH = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE         = 2'd0,
        ST_CHANGED      = 2'd1,
        ST_UNCHANGED    = 2'd2,
        ST_DISCONNECTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] read_period_ticks;
        logic [TIMER_W-1:0]  latch_ticks;
        logic [TIMER_W-1:0]  clock_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 latch_level;
        logic                 clock_level;
        logic [BUTTONS_W-1:0] buttons;
        status_t              read_status;
    } result_t;

endpackage

@@ design/gamepad_shift_reader_core.sv @@
// top level of the gamepad shift reader: configuration registers and channels
// depends on gsr_pkg, gsr_sequencer and gsr_out_buffer
//
// Reads a serial gamepad through its latch, clock and data pins. Each input
// transfer is one timebase tick (normally one microsecond) carrying the data
// pin level; each tick yields exactly one output transfer with the latch and
// clock pin levels for that tick, the most recent button word (bit set means
// pressed) and a status that is nonzero on the tick a read finishes: 1 changed,
// 2 unchanged, 3 disconnected (all buttons seen pressed; the compare word is not
// updated). A read starts once read_period_ticks ticks have passed since the
// end of the last latch pulse, holds latch for latch_ticks ticks, then clocks
// in 16 bits msb first, each with clock_half_ticks low then high. The block
// takes one tick per clock cycle: the whole tick update is one pass through
// the sequencer, whose result lands in a two-entry output buffer, so input
// transfers continue while one result waits and stall only once both entries
// hold results. Configuration writes take effect on the next edge and should
// be made while no transfer is in flight.
module gamepad_shift_reader_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [gsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tick input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            data_level,
    // result output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            latch_level,
    output logic                            clock_level,
    output logic [gsr_pkg::BUTTONS_W-1:0]   buttons,
    output logic [1:0]                      read_status
);
    import gsr_pkg::*;

    cfg_t    cfg_reg;
    result_t step_result;
    result_t out_result;
    logic    in_take;
    logic    buffer_full;

    // configuration registers, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_period_ticks <= RESET_READ_PERIOD;
            cfg_reg.latch_ticks       <= RESET_LATCH;
            cfg_reg.clock_half_ticks  <= RESET_CLOCK_HALF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_READ_PERIOD: cfg_reg.read_period_ticks <= cfg_data[PERIOD_W-1:0];
                REG_LATCH:       cfg_reg.latch_ticks       <= cfg_data[TIMER_W-1:0];
                REG_CLOCK_HALF:  cfg_reg.clock_half_ticks  <= cfg_data[TIMER_W-1:0];
                default:         ;
            endcase
        end
    end

    // an input transfer happens whenever the buffer still has a free entry
    assign in_stall = buffer_full;
    assign in_take  = in_valid && !buffer_full;

    // one tick of the read sequence per accepted transfer
    gsr_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_take),
        .data_level (data_level),
        .cfg        (cfg_reg),
        .result     (step_result)
    );

    // result register with skid entry toward the output channel
    gsr_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_data (step_result),
        .full      (buffer_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign latch_level = out_result.latch_level;
    assign clock_level = out_result.clock_level;
    assign buttons     = out_result.buttons;
    assign read_status = out_result.read_status;

endmodule

@@ design/gsr_sequencer.sv @@
// per-tick read sequencer: phase machine, timers, shift word and classification
// depends on gsr_pkg
module gsr_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            data_level,
    input  gsr_pkg::cfg_t   cfg,
    output gsr_pkg::result_t result
);
    import gsr_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_W-1:0]     timer_reg, timer_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [BUTTON_BITS-1:0] shift_reg, shift_next;
    logic [PERIOD_W-1:0]    count_reg, count_next;
    logic [BUTTON_BITS-1:0] captured_reg, captured_next;
    logic [BUTTON_BITS-1:0] previous_reg, previous_next;

    logic [TIMER_W-1:0]     timer_inc;
    logic [PERIOD_W-1:0]    count_inc;
    logic [BIT_IDX_W-1:0]   bit_inc;
    logic [BUTTON_BITS-1:0] word;
    logic                   latch_done;
    logic                   half_done;
    status_t                status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            timer_reg    <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            count_reg    <= '0;
            captured_reg <= '0;
            previous_reg <= WORD_ONES;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            captured_reg <= captured_next;
            previous_reg <= previous_next;
        end
    end

    // a zero length is met by any count, so it ends after one tick; a timer roll over also ends it
    assign timer_inc  = timer_reg + 1'b1;
    assign latch_done = (timer_inc >= cfg.latch_ticks) || (timer_inc == '0);
    assign half_done  = (timer_inc >= cfg.clock_half_ticks) || (timer_inc == '0);
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign bit_inc    = bit_reg + 1'b1;
    assign word       = ~shift_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        captured_next = captured_reg;
        previous_next = previous_reg;
        status        = ST_NONE;
        result.latch_level = 1'b0;
        result.clock_level = 1'b1;

        case (phase_reg)
            PH_IDLE:
            begin
                count_next = count_inc;
                if (count_inc >= cfg.read_period_ticks)
                begin
                    phase_next = PH_LATCH;
                    timer_next = '0;
                end
            end
            PH_LATCH:
            begin
                result.latch_level = 1'b1;
                timer_next = timer_inc;
                if (latch_done)
                begin
                    phase_next = PH_CLK_LOW;
                    timer_next = '0;
                    bit_next   = '0;
                    shift_next = '0;
                    count_next = '0;
                end
            end
            PH_CLK_LOW:
            begin
                result.clock_level = 1'b0;
                count_next = count_inc;
                timer_next = timer_inc;
                if (half_done)
                begin
                    // msb first
                    shift_next = {shift_reg[BUTTON_BITS-2:0], data_level};
                    phase_next = PH_CLK_HIGH;
                    timer_next = '0;
                end
            end
            default:
            begin
                count_next = count_inc;
                timer_next = timer_inc;
                if (half_done)
                begin
                    timer_next = '0;
                    if (bit_inc >= BIT_IDX_W'(BUTTON_BITS))
                    begin
                        captured_next = word;
                        if (word == WORD_ONES)
                            status = ST_DISCONNECTED;
                        else if (word != previous_reg)
                        begin
                            previous_next = word;
                            status = ST_CHANGED;
                        end
                        else
                            status = ST_UNCHANGED;
                        phase_next = PH_IDLE;
                        bit_next   = '0;
                    end
                    else
                    begin
                        bit_next   = bit_inc;
                        phase_next = PH_CLK_LOW;
                    end
                end
            end
        endcase

        result.buttons     = BUTTONS_W'(captured_next);
        result.read_status = status;
    end

endmodule

@@ design/gsr_out_buffer.sv @@
// two-entry output buffer: result register plus skid register
// depends on gsr_pkg
module gsr_out_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gsr_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output gsr_pkg::result_t out_data
);
    import gsr_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || take)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || take)
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        else if (push)
            skid_reg <= push_data;
    end

endmodule
